### rtl/dmxp_pkg.sv
package dmxp_pkg;

  localparam int unsigned CHANNELS = 512;
  localparam int unsigned ADDR_W   = $clog2(CHANNELS);
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned POS_W    = CNT_W + 1;
  localparam int unsigned IDX_W    = 9;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_WRITE = 2'd0;
  localparam cmd_t CMD_FETCH = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  localparam byte_t HDR_START = 8'd4;
  localparam byte_t HDR_BULK  = 8'd2;
  localparam byte_t HDR_END   = 8'd3;

  localparam logic [CNT_W-1:0] CHAN_LIMIT = CNT_W'(CHANNELS);
  localparam logic [CNT_W-1:0] COUNT_RST  = CNT_W'(16);
  localparam logic [POS_W-1:0] TAIL_LEN   = POS_W'(6);
  localparam logic [2:0]       START_LEN  = 3'd6;
  localparam logic [2:0]       BULK_LEN   = 3'd7;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic             fire;
    logic             frame_done;
    byte_t [7:0]      bytes;
  } dmxp_res_t;

endpackage

### rtl/dmxp_store.sv
module dmxp_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [dmxp_pkg::ADDR_W-1:0] waddr_i,
  input  dmxp_pkg::byte_t             wdata_i,
  input  logic [dmxp_pkg::ADDR_W-1:0] raddr_i,
  output dmxp_pkg::byte_t             rdata_o
);
  import dmxp_pkg::*;

  byte_t mem_q [CHANNELS];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dmxp_engine.sv
module dmxp_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_i,
  input  dmxp_pkg::cmd_t              command_i,
  input  logic [dmxp_pkg::IDX_W-1:0]  channel_index_i,
  input  dmxp_pkg::byte_t             channel_value_i,
  input  logic [dmxp_pkg::CNT_W-1:0]  count_i,
  input  logic                        out_free_i,
  output logic                        ready_o,
  output dmxp_pkg::dmxp_res_t         res_o,
  output logic                        mem_we_o,
  output logic [dmxp_pkg::ADDR_W-1:0] mem_waddr_o,
  output dmxp_pkg::byte_t             mem_wdata_o,
  output logic [dmxp_pkg::ADDR_W-1:0] mem_raddr_o,
  input  dmxp_pkg::byte_t             mem_rdata_i
);
  import dmxp_pkg::*;

  state_e            state_q;
  logic [ADDR_W-1:0] clr_q;
  logic              phase_q;
  logic [CNT_W-1:0]  pos_q;
  logic [CNT_W-1:0]  iss_q;
  logic [CNT_W-1:0]  ret_q;
  logic              rvld_q;
  logic              scan_q;
  logic              start_q;
  logic              end_q;
  logic [2:0]        slot_q;
  logic [2:0]        left_q;
  logic              done_q;
  byte_t [7:0]       pkt_q;

  logic             is_bulk;
  logic [CNT_W-1:0] remain;
  logic [2:0]       tail_cnt;
  byte_t            rbyte;
  logic             skip;
  logic             take;
  logic             last;
  logic [CNT_W-1:0] nxt;
  logic             fin;

  // Decision for the next packet of a frame that is already running.
  assign is_bulk  = ({1'b0, pos_q} + TAIL_LEN) < {1'b0, count_i};
  assign remain   = count_i - pos_q;
  assign tail_cnt = (pos_q < count_i) ? remain[2:0] : 3'd0;

  // Read data returns in the cycle after the address; channels past the store read zero.
  assign rbyte = (ret_q < CHAN_LIMIT) ? mem_rdata_i : '0;
  assign skip  = scan_q && (ret_q < count_i) && (rbyte == '0);
  assign take  = (state_q == ST_READ) && rvld_q && !skip;
  assign last  = take && (left_q == 3'd1);
  assign nxt   = ret_q + CNT_W'(1);
  assign fin   = end_q || (start_q && (nxt >= count_i));

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = channel_index_i[ADDR_W-1:0];
    mem_wdata_o = channel_value_i;
    if (state_q == ST_CLEAR) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = clr_q;
      mem_wdata_o = '0;
    end else if ((state_q == ST_IDLE) && req_i && (command_i == CMD_WRITE)) begin
      mem_we_o = ({1'b0, channel_index_i} < CHAN_LIMIT);
    end
  end

  assign mem_raddr_o = iss_q[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      phase_q <= 1'b0;
      pos_q   <= '0;
      iss_q   <= '0;
      ret_q   <= '0;
      rvld_q  <= 1'b0;
      scan_q  <= 1'b0;
      start_q <= 1'b0;
      end_q   <= 1'b0;
      slot_q  <= '0;
      left_q  <= '0;
      done_q  <= 1'b0;
      pkt_q   <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(CHANNELS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          rvld_q <= 1'b0;
          if (req_i) begin
            case (command_i)
              CMD_CLEAR: begin
                clr_q   <= '0;
                state_q <= ST_CLEAR;
              end
              CMD_FETCH: begin
                if (!phase_q) begin
                  start_q  <= 1'b1;
                  end_q    <= 1'b0;
                  scan_q   <= 1'b1;
                  iss_q    <= '0;
                  slot_q   <= 3'd2;
                  left_q   <= START_LEN;
                  pkt_q[0] <= HDR_START;
                  state_q  <= ST_READ;
                end else if (is_bulk) begin
                  start_q  <= 1'b0;
                  end_q    <= 1'b0;
                  scan_q   <= 1'b0;
                  iss_q    <= pos_q;
                  slot_q   <= 3'd1;
                  left_q   <= BULK_LEN;
                  pkt_q[0] <= HDR_BULK;
                  state_q  <= ST_READ;
                end else begin
                  start_q  <= 1'b0;
                  end_q    <= 1'b1;
                  scan_q   <= 1'b0;
                  iss_q    <= pos_q;
                  slot_q   <= 3'd2;
                  left_q   <= tail_cnt;
                  pkt_q[0] <= HDR_END;
                  pkt_q[1] <= byte_t'(tail_cnt);
                  if (tail_cnt == 3'd0) begin
                    // Nothing left to send: the end packet closes the frame at once.
                    done_q  <= 1'b1;
                    phase_q <= 1'b0;
                    pos_q   <= '0;
                    state_q <= ST_WAIT;
                  end else begin
                    state_q <= ST_READ;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          iss_q  <= iss_q + CNT_W'(1);
          ret_q  <= iss_q;
          rvld_q <= !last;
          if (take) begin
            if (scan_q) begin
              pkt_q[1] <= nxt[7:0];
              scan_q   <= 1'b0;
            end
            pkt_q[slot_q] <= rbyte;
            slot_q        <= slot_q + 3'd1;
            left_q        <= left_q - 3'd1;
          end
          if (last) begin
            done_q  <= fin;
            phase_q <= !fin;
            pos_q   <= fin ? '0 : nxt;
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign ready_o          = (state_q == ST_IDLE);
  assign res_o.fire       = (state_q == ST_WAIT) && out_free_i;
  assign res_o.frame_done = done_q;
  assign res_o.bytes      = pkt_q;

endmodule

### rtl/dmx_channel_packetizer_unit.sv
// Channel   Handshake                 Payload
// in        in_valid_i / in_stall_o   command_i, channel_index_i, channel_value_i
// out       out_valid_o / out_stall_i byte0_o .. byte7_o, frame_done_o
// cfg       cfg_we_i                  cfg_data_i (channel count)
//
// A write or unused command leaves the engine idle; a clear sweeps the store to zero.
// A fetch reads one store byte per cycle through the single read port; a start packet
// first skips leading zero channels; an end packet with nothing left reads no byte.
// After reset the store is swept to zero with in_stall_o high.
// One finished packet waits in the output register; a later fetch holds in the engine
// until that register is free.
module dmx_channel_packetizer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  dmxp_pkg::cmd_t             command_i,
  input  logic [dmxp_pkg::IDX_W-1:0] channel_index_i,
  input  dmxp_pkg::byte_t            channel_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output dmxp_pkg::byte_t            byte0_o,
  output dmxp_pkg::byte_t            byte1_o,
  output dmxp_pkg::byte_t            byte2_o,
  output dmxp_pkg::byte_t            byte3_o,
  output dmxp_pkg::byte_t            byte4_o,
  output dmxp_pkg::byte_t            byte5_o,
  output dmxp_pkg::byte_t            byte6_o,
  output dmxp_pkg::byte_t            byte7_o,
  output logic                       frame_done_o,
  input  logic                       cfg_we_i,
  input  logic [dmxp_pkg::CNT_W-1:0] cfg_data_i
);
  import dmxp_pkg::*;

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_eff;
  logic              ready;
  logic              req;
  logic              out_free;
  dmxp_res_t         res;
  logic              out_valid_q;
  logic              out_done_q;
  byte_t [7:0]       out_bytes_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  byte_t             mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  byte_t             mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RST;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  // A count above the store size is taken as the store size.
  assign count_eff = (count_q > CHAN_LIMIT) ? CHAN_LIMIT : count_q;

  assign req        = in_valid_i && ready;
  assign in_stall_o = !ready;
  assign out_free   = !out_valid_q || !out_stall_i;

  dmxp_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .command_i      (command_i),
    .channel_index_i(channel_index_i),
    .channel_value_i(channel_value_i),
    .count_i        (count_eff),
    .out_free_i     (out_free),
    .ready_o        (ready),
    .res_o          (res),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  dmxp_store u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.fire) begin
      out_bytes_q <= res.bytes;
      out_done_q  <= res.frame_done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte0_o      = out_bytes_q[0];
  assign byte1_o      = out_bytes_q[1];
  assign byte2_o      = out_bytes_q[2];
  assign byte3_o      = out_bytes_q[3];
  assign byte4_o      = out_bytes_q[4];
  assign byte5_o      = out_bytes_q[5];
  assign byte6_o      = out_bytes_q[6];
  assign byte7_o      = out_bytes_q[7];
  assign frame_done_o = out_done_q;

  // A finished packet is only handed over when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.fire |-> (!out_valid_q || !out_stall_i))
    else $error("packet handed over while output register is occupied");

  // The engine is never idle while it hands over a packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.fire |-> in_stall_o)
    else $error("packet handed over while accepting items");

  // A clear command starts the sweep, so the block is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (command_i == CMD_CLEAR)) |=> in_stall_o)
    else $error("clear command did not start the store sweep");

  // Only start and end packets can close a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> ((byte0_o == HDR_START) || (byte0_o == HDR_END)))
    else $error("bulk packet marked as last of frame");

endmodule
